[rtl/core/wall_texture_coordinate_defines.svh]
// ----------------------------------------------------------------------------
// wall_texture_coordinate_defines: assertion macros
// Shared concurrent assertion forms for the texture coordinate block.
// ----------------------------------------------------------------------------
`ifndef WALL_TEXTURE_COORDINATE_DEFINES_SVH
`define WALL_TEXTURE_COORDINATE_DEFINES_SVH

// condition true at every clock edge outside reset
`define WTC_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define WTC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/wtc_pkg.sv]
// ----------------------------------------------------------------------------
// wtc_pkg: wall texture coordinate package
// Field widths, texture index codes and the beat carried along the cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtc_pkg;

  localparam int POS_W   = 22;
  localparam int DIR_W   = 16;
  localparam int DIST_W  = 24;
  localparam int HGT_W   = 16;
  localparam int ROW_W   = 10;
  localparam int FRAC_W  = 16;
  localparam int COL_W   = 6;
  localparam int STEP_W  = 23;
  localparam int TROW_W  = 34;
  localparam int IDX_W   = 2;
  localparam int OFS_W   = 17;
  localparam int DIV_W   = HGT_W;
  localparam int MUL_W   = DIST_W + 1 + DIR_W;
  localparam int FRAC_LO = 14;

  localparam logic [IDX_W-1:0] TEX_Y_NEG = 2'd0;
  localparam logic [IDX_W-1:0] TEX_Y_POS = 2'd1;
  localparam logic [IDX_W-1:0] TEX_X_NEG = 2'd2;
  localparam logic [IDX_W-1:0] TEX_X_POS = 2'd3;

  typedef struct packed {
    logic [FRAC_W-1:0]       frac;
    logic                    mirror;
    logic [IDX_W-1:0]        tex;
    logic signed [OFS_W-1:0] offset;
  } pay_t;

endpackage

[rtl/core/wtc_front.sv]
// ----------------------------------------------------------------------------
// wtc_front: hit position front end
// Two stages: distance times direction with divisor set-up, then wall fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtc_front #(
  parameter int SCREEN_ROWS = 480
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic                             hit_side,
  input  logic signed [wtc_pkg::DIR_W-1:0] dir_x,
  input  logic signed [wtc_pkg::DIR_W-1:0] dir_y,
  input  logic [wtc_pkg::DIST_W-1:0]       wall_distance,
  input  logic [wtc_pkg::HGT_W-1:0]        column_height,
  input  logic [wtc_pkg::ROW_W-1:0]        first_row,
  input  logic [wtc_pkg::FRAC_W-1:0]       pos_x,
  input  logic [wtc_pkg::FRAC_W-1:0]       pos_y,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output wtc_pkg::pay_t                    dn_pay,
  output logic [wtc_pkg::DIV_W-1:0]        dn_div
);
  import wtc_pkg::*;

  localparam logic signed [OFS_W-1:0] HALF_ROWS = OFS_W'(SCREEN_ROWS / 2);

  logic signed [MUL_W-1:0] prod;
  logic                    dx_pos;
  logic                    dy_pos;
  logic                    dy_neg;
  logic [IDX_W-1:0]        tex;
  logic                    mirror;
  logic signed [OFS_W-1:0] offset;
  logic [DIV_W-1:0]        divisor;

  logic                    s1_valid;
  logic                    s1_ready;
  logic [FRAC_W-1:0]       s1_part;
  logic [FRAC_W-1:0]       s1_pos;
  logic                    s1_mirror;
  logic [IDX_W-1:0]        s1_tex;
  logic signed [OFS_W-1:0] s1_offset;
  logic [DIV_W-1:0]        s1_div;

  logic                    s2_valid;
  logic                    s2_ready;
  pay_t                    s2_pay;
  logic [DIV_W-1:0]        s2_div;

  assign prod    = $signed({1'b0, wall_distance}) * (hit_side ? dir_x : dir_y);
  assign dx_pos  = !dir_x[DIR_W-1] && (dir_x != '0);
  assign dy_pos  = !dir_y[DIR_W-1] && (dir_y != '0);
  assign dy_neg  = dir_y[DIR_W-1];
  assign mirror  = hit_side ? dy_neg : dx_pos;
  assign divisor = (column_height == '0) ? DIV_W'(1) : column_height;
  assign offset  = $signed(OFS_W'(first_row)) + $signed(OFS_W'(column_height[HGT_W-1:1]))
                   - HALF_ROWS;

  always_comb begin
    if (hit_side) begin
      tex = dy_pos ? TEX_Y_POS : TEX_Y_NEG;
    end else begin
      tex = dx_pos ? TEX_X_POS : TEX_X_NEG;
    end
  end

  assign s2_ready = !s2_valid || dn_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s1_ready) begin
      s1_part   <= prod[FRAC_LO+FRAC_W-1:FRAC_LO];
      s1_pos    <= hit_side ? pos_x : pos_y;
      s1_mirror <= mirror;
      s1_tex    <= tex;
      s1_offset <= offset;
      s1_div    <= divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_pay.frac   <= s1_pos + s1_part;
      s2_pay.mirror <= s1_mirror;
      s2_pay.tex    <= s1_tex;
      s2_pay.offset <= s1_offset;
      s2_div        <= s1_div;
    end
  end

  assign dn_valid = s2_valid;
  assign dn_pay   = s2_pay;
  assign dn_div   = s2_div;

endmodule

[rtl/core/wtc_div_cell.sv]
// ----------------------------------------------------------------------------
// wtc_div_cell: one restoring division step
// Takes one dividend bit, yields one quotient bit, passes the beat on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtc_div_cell #(
  parameter int DW   = 23,
  parameter bit DBIT = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  wtc_pkg::pay_t             up_pay,
  input  logic [wtc_pkg::DIV_W-1:0] up_div,
  input  logic [wtc_pkg::DIV_W-1:0] up_rem,
  input  logic [DW-1:0]             up_quo,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output wtc_pkg::pay_t             dn_pay,
  output logic [wtc_pkg::DIV_W-1:0] dn_div,
  output logic [wtc_pkg::DIV_W-1:0] dn_rem,
  output logic [DW-1:0]             dn_quo
);
  import wtc_pkg::*;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic [DIV_W-1:0] rem_next;
  logic [DW-1:0]    quo_next;
  logic             valid;

  assign trial    = {up_rem, DBIT};
  assign diff     = trial - {1'b0, up_div};
  assign ge       = trial >= {1'b0, up_div};
  assign rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  assign quo_next = {up_quo[DW-2:0], ge};

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_pay <= up_pay;
      dn_div <= up_div;
      dn_rem <= rem_next;
      dn_quo <= quo_next;
    end
  end

  assign dn_valid = valid;

endmodule

[rtl/core/wtc_back.sv]
// ----------------------------------------------------------------------------
// wtc_back: output stage
// Texture column with mirroring, start row product, registered result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtc_back #(
  parameter int DW        = 23,
  parameter int TEXTURE_W = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  wtc_pkg::pay_t                     up_pay,
  input  logic [DW-1:0]                     up_quo,
  output logic                              dn_valid,
  input  logic                              dn_stall,
  output logic [wtc_pkg::FRAC_W-1:0]        wall_frac,
  output logic [wtc_pkg::COL_W-1:0]         texel_column,
  output logic [wtc_pkg::STEP_W-1:0]        row_step,
  output logic signed [wtc_pkg::TROW_W-1:0] start_texel_row,
  output logic [wtc_pkg::IDX_W-1:0]         texture_index
);
  import wtc_pkg::*;

  localparam int CW  = $clog2(TEXTURE_W);
  localparam int CPW = FRAC_W + CW + 1;
  localparam int CXW = (CW > COL_W) ? CW : COL_W;
  localparam int SXW = (DW > STEP_W) ? DW : STEP_W;
  localparam int TPW = OFS_W + DW + 1;

  logic [CPW-1:0]        cprod;
  logic [CW-1:0]         col;
  logic [CW-1:0]         col_mir;
  logic [CXW-1:0]        col_ext;
  logic [SXW-1:0]        step_ext;
  logic signed [TPW-1:0] tprod;
  logic                  valid;

  assign cprod    = CPW'(up_pay.frac) * CPW'(TEXTURE_W);
  assign col      = cprod[FRAC_W+CW-1:FRAC_W];
  assign col_mir  = CW'(TEXTURE_W - 1) - col;
  assign col_ext  = CXW'(up_pay.mirror ? col_mir : col);
  assign step_ext = SXW'(up_quo);
  assign tprod    = up_pay.offset * $signed({1'b0, up_quo});

  assign up_ready = !valid || !dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      wall_frac       <= up_pay.frac;
      texel_column    <= col_ext[COL_W-1:0];
      row_step        <= step_ext[STEP_W-1:0];
      start_texel_row <= $signed(tprod[TROW_W-1:0]);
      texture_index   <= up_pay.tex;
    end
  end

  assign dn_valid = valid;

endmodule

[rtl/core/wall_texture_coordinate.sv]
// ----------------------------------------------------------------------------
// wall_texture_coordinate: ray caster wall texture coordinate
// Per-ray texture column, row step, start row and texture select.
// ----------------------------------------------------------------------------
// Usage: one ray hit beat enters on ray_valid/ray_stall, one result beat
// leaves on coord_valid/coord_stall. A beat moves at a clock edge with valid
// high and stall low. Player position is written over the APB port (x at
// 0x0, y at 0x4) while no ray is in flight.
// Path: two front stages, one division cell per quotient bit of
// TEXTURE_H * 65536 / height (DW = clog2(TEXTURE_H + 1) + 16 bits), and the
// output register.
// Throughput: one ray per cycle while nothing stalls; each division cell
// retires one quotient bit per beat, so a new ray can enter every cycle.
// Reset clears the positions and every stage valid; no result is pending.
// Stall: the output register holds its beat while coord_stall is high;
// earlier stages keep closing up gaps and ray_stall rises only once every
// stage holds a beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wall_texture_coordinate #(
  parameter int TEXTURE_W   = 64,
  parameter int TEXTURE_H   = 64,
  parameter int SCREEN_ROWS = 480
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              ray_valid,
  output logic                              ray_stall,
  input  logic                              hit_side,
  input  logic signed [wtc_pkg::DIR_W-1:0]  dir_x,
  input  logic signed [wtc_pkg::DIR_W-1:0]  dir_y,
  input  logic [wtc_pkg::DIST_W-1:0]        wall_distance,
  input  logic [wtc_pkg::HGT_W-1:0]         column_height,
  input  logic [wtc_pkg::ROW_W-1:0]         first_row,
  output logic                              coord_valid,
  input  logic                              coord_stall,
  output logic [wtc_pkg::FRAC_W-1:0]        wall_frac,
  output logic [wtc_pkg::COL_W-1:0]         texel_column,
  output logic [wtc_pkg::STEP_W-1:0]        row_step,
  output logic signed [wtc_pkg::TROW_W-1:0] start_texel_row,
  output logic [wtc_pkg::IDX_W-1:0]         texture_index
);
  import wtc_pkg::*;

`include "wall_texture_coordinate_defines.svh"

  localparam int DW = $clog2(TEXTURE_H + 1) + 16;
  localparam logic [DW-1:0] DIVIDEND = DW'(TEXTURE_H) << 16;

  localparam logic REG_POS_X = 1'b0;
  localparam logic REG_POS_Y = 1'b1;

  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             front_ready;

  logic             chain_valid [DW+1];
  logic             chain_ready [DW+1];
  pay_t             chain_pay   [DW+1];
  logic [DIV_W-1:0] chain_div   [DW+1];
  logic [DIV_W-1:0] chain_rem   [DW+1];
  logic [DW-1:0]    chain_quo   [DW+1];

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_POS_X: pos_x <= pwdata[POS_W-1:0];
        REG_POS_Y: pos_y <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POS_X: prdata = 32'(pos_x);
      REG_POS_Y: prdata = 32'(pos_y);
      default:   prdata = '0;
    endcase
  end

  // front end
  wtc_front #(
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (ray_valid),
    .up_ready     (front_ready),
    .hit_side     (hit_side),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .wall_distance(wall_distance),
    .column_height(column_height),
    .first_row    (first_row),
    .pos_x        (pos_x[FRAC_W-1:0]),
    .pos_y        (pos_y[FRAC_W-1:0]),
    .dn_valid     (chain_valid[0]),
    .dn_ready     (chain_ready[0]),
    .dn_pay       (chain_pay[0]),
    .dn_div       (chain_div[0])
  );

  assign ray_stall    = !front_ready;
  assign chain_rem[0] = '0;
  assign chain_quo[0] = '0;

  // division row, most significant quotient bit first
  for (genvar k = 0; k < DW; k++) begin : g_cell
    wtc_div_cell #(
      .DW  (DW),
      .DBIT(DIVIDEND[DW-1-k])
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(chain_valid[k]),
      .up_ready(chain_ready[k]),
      .up_pay  (chain_pay[k]),
      .up_div  (chain_div[k]),
      .up_rem  (chain_rem[k]),
      .up_quo  (chain_quo[k]),
      .dn_valid(chain_valid[k+1]),
      .dn_ready(chain_ready[k+1]),
      .dn_pay  (chain_pay[k+1]),
      .dn_div  (chain_div[k+1]),
      .dn_rem  (chain_rem[k+1]),
      .dn_quo  (chain_quo[k+1])
    );
  end

  wtc_back #(
    .DW       (DW),
    .TEXTURE_W(TEXTURE_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (chain_valid[DW]),
    .up_ready       (chain_ready[DW]),
    .up_pay         (chain_pay[DW]),
    .up_quo         (chain_quo[DW]),
    .dn_valid       (coord_valid),
    .dn_stall       (coord_stall),
    .wall_frac      (wall_frac),
    .texel_column   (texel_column),
    .row_step       (row_step),
    .start_texel_row(start_texel_row),
    .texture_index  (texture_index)
  );

  `WTC_ASSERT_HOLDS(a_empty_no_stall, clk, rst, coord_valid || !ray_stall, "ray stalled with empty output")
  `WTC_ASSERT_IMPLIES(a_rem_bound, clk, rst, chain_valid[DW], chain_rem[DW] < chain_div[DW], "remainder not below divisor")
  `WTC_ASSERT_IMPLIES(a_step_nonzero, clk, rst, chain_valid[DW], chain_quo[DW] != '0, "zero row step quotient")
  `WTC_ASSERT_IMPLIES(a_mirror_tex, clk, rst, chain_valid[DW] && (chain_pay[DW].tex == TEX_X_POS || chain_pay[DW].tex == TEX_X_NEG || chain_pay[DW].tex == TEX_Y_POS), chain_pay[DW].mirror == (chain_pay[DW].tex == TEX_X_POS), "mirror flag disagrees with texture index")

endmodule

[dv/tb_wall_texture_coordinate.sv]
// ----------------------------------------------------------------------------
// tb_wall_texture_coordinate: texture coordinate block testbench
// Drives ray hit beats with random gaps and result stalls, writes the player
// position over APB between phases, predicts every result beat in a small
// scoreboard and compares it field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic                                hit_side;
  logic signed [wtc_pkg::DIR_W-1:0]    dir_x;
  logic signed [wtc_pkg::DIR_W-1:0]    dir_y;
  logic [wtc_pkg::DIST_W-1:0]          wall_distance;
  logic [wtc_pkg::HGT_W-1:0]           column_height;
  logic [wtc_pkg::ROW_W-1:0]           first_row;
} ray_t;

typedef struct {
  logic [wtc_pkg::FRAC_W-1:0]          frac;
  logic [wtc_pkg::COL_W-1:0]           column;
  logic [wtc_pkg::STEP_W-1:0]          step;
  logic signed [wtc_pkg::TROW_W-1:0]   trow;
  logic [wtc_pkg::IDX_W-1:0]           tex;
} coord_t;

class coord_scoreboard;
  localparam int TEXTURE_W   = 64;
  localparam int TEXTURE_H   = 64;
  localparam int SCREEN_ROWS = 480;

  logic [wtc_pkg::POS_W-1:0] pos_x;
  logic [wtc_pkg::POS_W-1:0] pos_y;
  coord_t                    pending_coords[$];
  int                        errors;

  function new();
    pos_x = '0;
    pos_y = '0;
    errors = 0;
  endfunction

  function coord_t texel_coords_for(ray_t r);
    coord_t c;
    longint pos, dir, prod, hit, h, step, offset;
    logic   mirror;
    pos = r.hit_side ? pos_x : pos_y;
    if (r.hit_side) begin
      dir = r.dir_x;
    end else begin
      dir = r.dir_y;
    end
    // hit point in Q.30, wraps freely; only the fraction bits matter
    prod = longint'(r.wall_distance) * dir;
    hit = (pos << 14) + prod;
    c.frac = hit[29:14];
    c.column = 6'((longint'(c.frac) * TEXTURE_W) >> 16);
    mirror = (!r.hit_side && r.dir_x > 0) || (r.hit_side && r.dir_y < 0);
    if (mirror) c.column = 6'(TEXTURE_W - 1) - c.column;
    h = (r.column_height == 0) ? 1 : longint'(r.column_height);
    step = (longint'(TEXTURE_H) << 16) / h;
    offset = longint'(r.first_row) - SCREEN_ROWS / 2 + h / 2;
    c.step = 23'(step);
    c.trow = 34'(offset * step);
    if (r.hit_side) begin
      c.tex = (r.dir_y > 0) ? wtc_pkg::TEX_Y_POS : wtc_pkg::TEX_Y_NEG;
    end else begin
      c.tex = (r.dir_x > 0) ? wtc_pkg::TEX_X_POS : wtc_pkg::TEX_X_NEG;
    end
    return c;
  endfunction

  function void note_ray(ray_t r);
    pending_coords.push_back(texel_coords_for(r));
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function void check_coord(coord_t got);
    coord_t want;
    if (pending_coords.size() == 0) begin
      errors++;
      $display("%0t: result beat with no ray outstanding", $time);
      return;
    end
    want = pending_coords.pop_front();
    compare_field("wall_frac", want.frac, got.frac);
    compare_field("texel_column", want.column, got.column);
    compare_field("row_step", want.step, got.step);
    compare_field("start_texel_row", want.trow, got.trow);
    compare_field("texture_index", want.tex, got.tex);
  endfunction

  function int pending();
    return pending_coords.size();
  endfunction
endclass

module tb_wall_texture_coordinate;
  import wtc_pkg::*;

  localparam int           COORD_LATENCY = 26;
  localparam int           IDLE_LIMIT    = 2000;
  localparam int           PHASE_RAYS    = 200;
  localparam logic [2:0]   REG_POS_X     = 3'h0;
  localparam logic [2:0]   REG_POS_Y     = 3'h4;
  localparam logic [21:0]  POS_MAX       = 22'h3FFFFF;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       ray_valid;
  logic                       ray_stall;
  logic                       hit_side;
  logic signed [DIR_W-1:0]    dir_x;
  logic signed [DIR_W-1:0]    dir_y;
  logic [DIST_W-1:0]          wall_distance;
  logic [HGT_W-1:0]           column_height;
  logic [ROW_W-1:0]           first_row;
  logic                       coord_valid;
  logic                       coord_stall;
  logic [FRAC_W-1:0]          wall_frac;
  logic [COL_W-1:0]           texel_column;
  logic [STEP_W-1:0]          row_step;
  logic signed [TROW_W-1:0]   start_texel_row;
  logic [IDX_W-1:0]           texture_index;

  coord_scoreboard sb;
  int              idle_cycles;

  wall_texture_coordinate u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .ray_valid       (ray_valid),
    .ray_stall       (ray_stall),
    .hit_side        (hit_side),
    .dir_x           (dir_x),
    .dir_y           (dir_y),
    .wall_distance   (wall_distance),
    .column_height   (column_height),
    .first_row       (first_row),
    .coord_valid     (coord_valid),
    .coord_stall     (coord_stall),
    .wall_frac       (wall_frac),
    .texel_column    (texel_column),
    .row_step        (row_step),
    .start_texel_row (start_texel_row),
    .texture_index   (texture_index)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (ray_valid && !ray_stall) begin
        sb.note_ray('{hit_side, dir_x, dir_y, wall_distance, column_height, first_row});
      end
      if (coord_valid && !coord_stall) begin
        sb.check_coord('{wall_frac, texel_column, row_step, start_texel_row,
                         texture_index});
      end
      if ((ray_valid && !ray_stall) || (coord_valid && !coord_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side stalls: mostly short, a few long, stall-free runs between
  initial begin
    int unsigned r, n;
    coord_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 40) n = 0;
      else if (r < 85) n = $urandom_range(1, 3);
      else if (r < 95) n = $urandom_range(4, 12);
      else n = $urandom_range(20, 60);
      if (n > 0) begin
        coord_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      coord_stall = 1'b0;
      repeat ($urandom_range(1, (r < 10) ? 80 : 12)) @(negedge clk);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DIR_W-1:0] pick_dir();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (r)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'sh0001;
      4: return 16'shFFFF;
      default: return DIR_W'($urandom);
    endcase
  endfunction

  function automatic ray_t random_ray();
    ray_t        r;
    int unsigned sel;
    r.hit_side = 1'($urandom);
    r.dir_x = pick_dir();
    r.dir_y = pick_dir();
    sel = $urandom_range(0, 99);
    r.wall_distance = (sel < 65) ? DIST_W'($urandom_range(0, 24'h3FFFF)) : DIST_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 5) r.column_height = '0;
    else if (sel < 20) r.column_height = HGT_W'($urandom);
    else r.column_height = HGT_W'($urandom_range(1, 960));
    r.first_row = ROW_W'($urandom);
    return r;
  endfunction

  function automatic ray_t mk_ray(logic side, logic signed [DIR_W-1:0] dx,
                                  logic signed [DIR_W-1:0] dy, logic [DIST_W-1:0] wall_dist,
                                  logic [HGT_W-1:0] h, logic [ROW_W-1:0] row);
    ray_t r;
    r = '{side, dx, dy, wall_dist, h, row};
    return r;
  endfunction

  task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_position(input logic [21:0] px, input logic [21:0] py);
    logic [31:0] rd;
    apb_transfer(1'b1, REG_POS_X, {10'($urandom), px}, rd);
    sb.pos_x = px;
    apb_transfer(1'b1, REG_POS_Y, {10'($urandom), py}, rd);
    sb.pos_y = py;
    apb_transfer(1'b0, REG_POS_X, '0, rd);
    if (rd !== {10'b0, px}) begin
      sb.errors++;
      $display("%0t: player_pos_x readback, expected %0h, got %0h", $time, px, rd);
    end
    apb_transfer(1'b0, REG_POS_Y, '0, rd);
    if (rd !== {10'b0, py}) begin
      sb.errors++;
      $display("%0t: player_pos_y readback, expected %0h, got %0h", $time, py, rd);
    end
  endtask

  task automatic send_ray(input ray_t r, input int unsigned gap);
    if (gap > 0) begin
      ray_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    hit_side = r.hit_side;
    dir_x = r.dir_x;
    dir_y = r.dir_y;
    wall_distance = r.wall_distance;
    column_height = r.column_height;
    first_row = r.first_row;
    ray_valid = 1'b1;
    do @(posedge clk); while (ray_stall);
    @(negedge clk);
  endtask

  // hold off the sender until every outstanding result has been taken
  task automatic drain_rays(input int unsigned settle);
    ray_valid = 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic run_random(input int unsigned count, input bit burst);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) drain_rays(0);
      send_ray(random_ray(), burst ? 0 : pick_gap());
    end
  endtask

  task automatic run_directed();
    ray_t rays[$];
    rays.push_back(mk_ray(1'b0, 16'sh7FFF, 16'sh0000, 24'hFFFFFF, 16'hFFFF, 10'd1023));
    rays.push_back(mk_ray(1'b0, 16'sh8000, 16'sh0001, 24'h000000, 16'h0000, 10'd0));
    rays.push_back(mk_ray(1'b0, 16'sh0000, 16'sh8000, 24'hFFFFFF, 16'h0001, 10'd0));
    rays.push_back(mk_ray(1'b1, 16'sh0001, 16'sh7FFF, 24'h010000, 16'h0002, 10'd1023));
    rays.push_back(mk_ray(1'b1, 16'shFFFF, 16'sh8000, 24'hFFFFFF, 16'h0040, 10'd240));
    rays.push_back(mk_ray(1'b1, 16'sh0000, 16'sh0000, 24'h123456, 16'h01E0, 10'd0));
    rays.push_back(mk_ray(1'b0, 16'sh0001, 16'sh7FFF, 24'h000001, 16'h0003, 10'd512));
    rays.push_back(mk_ray(1'b1, 16'sh7FFF, 16'shFFFF, 24'h800000, 16'hFFFE, 10'd1));
    rays.push_back(mk_ray(1'b0, 16'shFFFF, 16'shFFFF, 24'h7FFFFF, 16'h0000, 10'd1023));
    rays.push_back(mk_ray(1'b1, 16'sh8000, 16'sh0001, 24'h000000, 16'hFFFF, 10'd0));
    rays.push_back(mk_ray(1'b0, 16'sh4000, 16'shC000, 24'h018000, 16'h0064, 10'd190));
    rays.push_back(mk_ray(1'b1, 16'sh2D41, 16'sh2D41, 24'h02A000, 16'h00F0, 10'd120));
    rays.push_back(mk_ray(1'b0, 16'shD2BF, 16'sh2D41, 24'hFFFFFF, 16'h8000, 10'd700));
    rays.push_back(mk_ray(1'b1, 16'sh2D41, 16'shD2BF, 24'h0000FF, 16'h0001, 10'd511));
    foreach (rays[i]) send_ray(rays[i], (i % 3 == 2) ? $urandom_range(1, 4) : 0);
  endtask

  initial begin
    logic [21:0] px[7];
    logic [21:0] py[7];
    sb = new();
    idle_cycles = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ray_valid = 1'b0;
    hit_side = 1'b0;
    dir_x = '0;
    dir_y = '0;
    wall_distance = '0;
    column_height = '0;
    first_row = '0;
    px = '{22'h0, POS_MAX, 22'h0, 22'($urandom), 22'($urandom), POS_MAX, 22'($urandom)};
    py = '{22'h0, POS_MAX, POS_MAX, 22'($urandom), 22'($urandom), 22'h0, 22'($urandom)};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_position(POS_MAX, 22'h0);
    run_directed();
    for (int p = 0; p < 7; p++) begin
      drain_rays(COORD_LATENCY + 8);
      set_position(px[p], py[p]);
      run_random(PHASE_RAYS, p == 2);
    end
    drain_rays(COORD_LATENCY + 8);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
